// ===== hdl/mi3_pkg.sv =====
`default_nettype none
package mi3_pkg;

    // fraction bits of the input and the shift that puts a cofactor into Q16.16 over det
    localparam int FRAC_IN   = 12;
    localparam int QSHIFT    = FRAC_IN + 16;

    // result word
    localparam int Q_BITS    = 32;
    localparam logic [Q_BITS-1:0] Q_POS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic [Q_BITS-1:0] Q_NEG_MAG = {1'b1, {(Q_BITS-1){1'b0}}};

    // pipeline depths: cofactor and determinant front, divider lane
    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = Q_BITS + 2;

endpackage
`default_nettype wire

// ===== hdl/matrix3_inverse_unit.sv =====
// throughput: one matrix per cycle while the output is not stalled; 5 front stages, 34 stages per divider lane, 1 merge
// a stalled output holds the whole pipeline; reset clears all valid flags
// reset is synchronous, active low; data registers are not reset
`default_nettype none
module matrix3_inverse_unit #(
    parameter int ELEM_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [ELEM_BITS-1:0]         i_m00,
    input  wire logic signed [ELEM_BITS-1:0]         i_m01,
    input  wire logic signed [ELEM_BITS-1:0]         i_m02,
    input  wire logic signed [ELEM_BITS-1:0]         i_m10,
    input  wire logic signed [ELEM_BITS-1:0]         i_m11,
    input  wire logic signed [ELEM_BITS-1:0]         i_m12,
    input  wire logic signed [ELEM_BITS-1:0]         i_m20,
    input  wire logic signed [ELEM_BITS-1:0]         i_m21,
    input  wire logic signed [ELEM_BITS-1:0]         i_m22,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r00,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r01,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r02,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r10,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r11,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r12,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r20,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r21,
    output logic signed [mi3_pkg::Q_BITS-1:0]        o_r22,
    output logic                                     o_singular,
    output logic                                     o_saturated
);
    import mi3_pkg::*;

    localparam int TOT = FRONT_LAT + LANE_LAT;

    logic                          w_en;
    logic signed [ELEM_BITS-1:0]   w_m [9];
    logic signed [2*ELEM_BITS:0]   w_adj [9];
    logic [3*ELEM_BITS+1:0]        w_dmag;
    logic                          w_dneg;
    logic                          w_singular;
    logic [Q_BITS-1:0]             w_val [9];
    logic [8:0]                    w_sat;

    logic                          r_vld [TOT];
    logic                          r_sng [LANE_LAT];
    logic                          r_o_valid;
    logic [Q_BITS-1:0]             r_r [9];
    logic                          r_singular;
    logic                          r_saturated;

    // whole pipeline advances unless a result waits to be taken
    assign w_en    = !r_o_valid || i_ready;
    assign o_ready = w_en && i_rst_n;

    assign w_m[0] = i_m00;
    assign w_m[1] = i_m01;
    assign w_m[2] = i_m02;
    assign w_m[3] = i_m10;
    assign w_m[4] = i_m11;
    assign w_m[5] = i_m12;
    assign w_m[6] = i_m20;
    assign w_m[7] = i_m21;
    assign w_m[8] = i_m22;

    // cofactors and determinant
    mi3_front #(
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_m        (w_m),
        .o_adj      (w_adj),
        .o_dmag     (w_dmag),
        .o_dneg     (w_dneg),
        .o_singular (w_singular)
    );

    // one divider lane per adjugate element
    for (genvar g = 0; g < 9; g++) begin : g_lane
        mi3_div_lane #(
            .ELEM_BITS (ELEM_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_adj  (w_adj[g]),
            .i_dmag (w_dmag),
            .i_dneg (w_dneg),
            .o_val  (w_val[g]),
            .o_sat  (w_sat[g])
        );
    end

    // valid flags through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < TOT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_o_valid <= r_vld[TOT-1];
        end
    end

    // singular flag alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sng[0] <= w_singular;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_sng[k] <= r_sng[k-1];
            end
        end
    end

    // merge: zero on a singular matrix, otherwise lane results and any clip
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_r[k] <= r_sng[LANE_LAT-1] ? '0 : w_val[k];
            end
            r_singular  <= r_sng[LANE_LAT-1];
            r_saturated <= !r_sng[LANE_LAT-1] && (|w_sat);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_r00       = r_r[0];
    assign o_r01       = r_r[1];
    assign o_r02       = r_r[2];
    assign o_r10       = r_r[3];
    assign o_r11       = r_r[4];
    assign o_r12       = r_r[5];
    assign o_r20       = r_r[6];
    assign o_r21       = r_r[7];
    assign o_r22       = r_r[8];
    assign o_singular  = r_singular;
    assign o_saturated = r_saturated;

endmodule
`default_nettype wire

// ===== hdl/mi3_front.sv =====
`default_nettype none
module mi3_front #(
    parameter int ELEM_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [ELEM_BITS-1:0] i_m [9],
    output logic signed [2*ELEM_BITS:0]      o_adj [9],
    output logic [3*ELEM_BITS+1:0]           o_dmag,
    output logic                             o_dneg,
    output logic                             o_singular
);
    import mi3_pkg::*;

    localparam int E  = ELEM_BITS;
    localparam int P  = 2 * E;
    localparam int A  = 2 * E + 1;
    localparam int DP = 3 * E + 1;
    localparam int DT = 3 * E + 3;
    localparam int DW = 3 * E + 2;

    logic signed [P-1:0]  r_p [18];
    logic signed [E-1:0]  r_m0 [3];
    logic signed [E-1:0]  r_m1 [3];
    logic signed [A-1:0]  r_adj1 [9];
    logic signed [A-1:0]  r_adj2 [9];
    logic signed [A-1:0]  r_adj3 [9];
    logic signed [A-1:0]  r_adj4 [9];
    logic signed [DP-1:0] r_dp [3];
    logic signed [DT-1:0] r_det;
    logic [DW-1:0]        r_dmag;
    logic                 r_dneg;
    logic                 r_singular;

    logic signed [DT-1:0] n_det_abs;

    // stage 0: the eighteen 2x2 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= P'(i_m[4]) * P'(i_m[8]);
            r_p[1]  <= P'(i_m[7]) * P'(i_m[5]);
            r_p[2]  <= P'(i_m[2]) * P'(i_m[7]);
            r_p[3]  <= P'(i_m[1]) * P'(i_m[8]);
            r_p[4]  <= P'(i_m[1]) * P'(i_m[5]);
            r_p[5]  <= P'(i_m[2]) * P'(i_m[4]);
            r_p[6]  <= P'(i_m[5]) * P'(i_m[6]);
            r_p[7]  <= P'(i_m[3]) * P'(i_m[8]);
            r_p[8]  <= P'(i_m[0]) * P'(i_m[8]);
            r_p[9]  <= P'(i_m[2]) * P'(i_m[6]);
            r_p[10] <= P'(i_m[3]) * P'(i_m[2]);
            r_p[11] <= P'(i_m[0]) * P'(i_m[5]);
            r_p[12] <= P'(i_m[3]) * P'(i_m[7]);
            r_p[13] <= P'(i_m[6]) * P'(i_m[4]);
            r_p[14] <= P'(i_m[6]) * P'(i_m[1]);
            r_p[15] <= P'(i_m[0]) * P'(i_m[7]);
            r_p[16] <= P'(i_m[0]) * P'(i_m[4]);
            r_p[17] <= P'(i_m[3]) * P'(i_m[1]);
            r_m0[0] <= i_m[0];
            r_m0[1] <= i_m[1];
            r_m0[2] <= i_m[2];
        end
    end

    // stage 1: cofactor differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_adj1[k] <= A'(r_p[2*k]) - A'(r_p[2*k+1]);
            end
            r_m1 <= r_m0;
        end
    end

    // stage 2: expansion along row 0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp[0] <= DP'(r_m1[0]) * DP'(r_adj1[0]);
            r_dp[1] <= DP'(r_m1[1]) * DP'(r_adj1[3]);
            r_dp[2] <= DP'(r_m1[2]) * DP'(r_adj1[6]);
            r_adj2  <= r_adj1;
        end
    end

    // stage 3: determinant sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= DT'(r_dp[0]) + DT'(r_dp[1]) + DT'(r_dp[2]);
            r_adj3 <= r_adj2;
        end
    end

    // stage 4: magnitude and sign of the determinant
    always_comb begin
        n_det_abs = r_det[DT-1] ? -r_det : r_det;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dmag     <= n_det_abs[DW-1:0];
            r_dneg     <= r_det[DT-1];
            r_singular <= (r_det == '0);
            r_adj4     <= r_adj3;
        end
    end

    assign o_adj      = r_adj4;
    assign o_dmag     = r_dmag;
    assign o_dneg     = r_dneg;
    assign o_singular = r_singular;

endmodule
`default_nettype wire

// ===== hdl/mi3_div_lane.sv =====
`default_nettype none
module mi3_div_lane #(
    parameter int ELEM_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [2*ELEM_BITS:0]     i_adj,
    input  wire logic [3*ELEM_BITS+1:0]          i_dmag,
    input  wire logic                            i_dneg,
    output logic [mi3_pkg::Q_BITS-1:0]           o_val,
    output logic                                 o_sat
);
    import mi3_pkg::*;

    localparam int E  = ELEM_BITS;
    localparam int A  = 2 * E + 1;
    localparam int CW = 2 * E;
    localparam int DW = 3 * E + 2;
    localparam int NW = CW + QSHIFT;

    logic [DW-1:0]     r_rem [Q_BITS+1];
    logic [Q_BITS-1:0] r_low [Q_BITS+1];
    logic [Q_BITS-1:0] r_q   [Q_BITS+1];
    logic [DW-1:0]     r_d   [Q_BITS+1];
    logic              r_neg [Q_BITS+1];
    logic              r_ovf [Q_BITS+1];
    logic [Q_BITS-1:0] r_val;
    logic              r_sat;

    logic signed [A-1:0] n_abs;
    logic [NW-1:0]       n_num;
    logic [DW-1:0]       n_hi;

    // prep: numerator magnitude, sign and quotient overflow test
    always_comb begin
        n_abs = i_adj[A-1] ? -i_adj : i_adj;
        n_num = {n_abs[CW-1:0], {QSHIFT{1'b0}}};
        n_hi  = DW'(n_num[NW-1:Q_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi;
            r_low[0] <= n_num[Q_BITS-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= i_dmag;
            r_neg[0] <= i_adj[A-1] ^ i_dneg;
            r_ovf[0] <= (n_hi >= i_dmag);
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 1; g <= Q_BITS; g++) begin : g_step
        logic [DW:0] n_t;
        logic [DW:0] n_diff;
        logic        n_ge;

        always_comb begin
            n_t    = {r_rem[g-1], r_low[g-1][Q_BITS-1]};
            n_ge   = (n_t >= {1'b0, r_d[g-1]});
            n_diff = n_t - {1'b0, r_d[g-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_ge ? n_diff[DW-1:0] : n_t[DW-1:0];
                r_low[g] <= {r_low[g-1][Q_BITS-2:0], 1'b0};
                r_q[g]   <= {r_q[g-1][Q_BITS-2:0], n_ge};
                r_d[g]   <= r_d[g-1];
                r_neg[g] <= r_neg[g-1];
                r_ovf[g] <= r_ovf[g-1];
            end
        end
    end

    // sign and clip
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[Q_BITS]) begin
                if (r_ovf[Q_BITS] || r_q[Q_BITS] > Q_POS_MAX) begin
                    r_val <= Q_POS_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= r_q[Q_BITS];
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_ovf[Q_BITS] || r_q[Q_BITS] > Q_NEG_MAG) begin
                    r_val <= Q_NEG_MAG;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= -r_q[Q_BITS];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule
`default_nettype wire
